### rtl/core/psu_pkg.sv
// Shared types, constants and the Paeth predictor for the PNG scanline unfilter.
package psu_pkg;

  localparam int ROW_BYTES_MAX = 131072;
  localparam int IDX_W         = $clog2(ROW_BYTES_MAX);
  localparam int ROW_W         = IDX_W + 1;
  localparam int PIX_MAX       = 8;
  localparam int BPP_W         = $clog2(PIX_MAX);
  localparam int BPP_REG_W     = 4;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  localparam logic CFG_ROW_BYTES = 1'b0;
  localparam logic CFG_BPP       = 1'b1;

  typedef struct packed {
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic [2:0]       filt;
    logic             bad;
    logic             first_row;
    logic             last;
    logic             left_ok;
    logic [BPP_W-1:0] bpp_sel;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic        [9:0] pa;
    logic        [9:0] pb;
    logic        [9:0] pc;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = da + db;
    pa = (da < 0) ? 10'(-da) : 10'(da);
    pb = (db < 0) ? 10'(-db) : 10'(db);
    pc = (dc < 0) ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

endpackage

### rtl/core/png_scanline_unfilter.sv
// A data byte passes through the request queue, the execute register and the output register before out_tvalid.
// Throughput: one byte per cycle while out_tready is high, set by the one-read, one-write line buffer and
// the combinational reconstruction step that feeds the next byte's left neighbor.
// Filter bytes are consumed from the stream and give no result.
// Reset (rst_n low, synchronous) clears the control state and the pixel windows; the
// line buffer is not cleared, since the first row of an image reads zero above.
module png_scanline_unfilter import psu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [ROW_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] data_byte
  input  logic             in_tuser,   // [0] image_start
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // [7:0] pixel_byte
  output logic             out_tlast,  // row_last
  output logic             out_tuser   // [0] bad_filter
);

  logic   q_push;
  logic   q_pop;
  item_t  q_in;
  item_t  q_head;
  qstat_t q_stat;

  psu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .data_byte   (in_tdata),
    .image_start (in_tuser),
    .q_full      (q_stat.full),
    .push        (q_push),
    .item        (q_in)
  );

  psu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  psu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_empty    (q_stat.empty),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .pixel_byte (out_tdata),
    .row_last   (out_tlast),
    .bad_filter (out_tuser)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_stat.full))
    else $error("request pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("request popped from an empty queue");

  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && q_stat.empty)
    else $error("result or queued request survives reset");

endmodule

### rtl/core/psu_front.sv
// Front end: config registers, row position tracking and classification of stream bytes.
module psu_front import psu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [ROW_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte,
  input  logic             image_start,
  input  logic             q_full,
  output logic             push,
  output item_t            item
);

  logic [ROW_W-1:0]     rb_r;
  logic [BPP_REG_W-1:0] bpp_r;
  logic                 in_row_r;
  logic [IDX_W-1:0]     idx_r;
  logic [7:0]           filt_r;
  logic                 first_r;

  logic [ROW_W-1:0]     rb_cl;
  logic [BPP_REG_W-1:0] bpp_cl;
  logic                 fire;
  logic                 expect_filter;
  logic                 last;

  assign in_ready      = !q_full;
  assign fire          = in_valid && in_ready;
  assign expect_filter = image_start || !in_row_r;
  assign push          = fire && !expect_filter;

  always_comb begin
    if (rb_r == '0) begin
      rb_cl = ROW_W'(1);
    end else if (rb_r > ROW_W'(ROW_BYTES_MAX)) begin
      rb_cl = ROW_W'(ROW_BYTES_MAX);
    end else begin
      rb_cl = rb_r;
    end
    if (bpp_r == '0) begin
      bpp_cl = BPP_REG_W'(1);
    end else if (bpp_r > BPP_REG_W'(PIX_MAX)) begin
      bpp_cl = BPP_REG_W'(PIX_MAX);
    end else begin
      bpp_cl = bpp_r;
    end
  end

  assign last = ({1'b0, idx_r} + ROW_W'(1)) >= rb_cl;

  always_comb begin
    item.data      = data_byte;
    item.idx       = idx_r;
    item.first_row = first_r;
    item.last      = last;
    item.left_ok   = idx_r >= IDX_W'(bpp_cl);
    item.bpp_sel   = BPP_W'(bpp_cl - BPP_REG_W'(1));
    // Unknown filter types pass the row through unchanged and flag it.
    if (filt_r > 8'(FILT_PAETH)) begin
      item.filt = FILT_NONE;
      item.bad  = 1'b1;
    end else begin
      item.filt = filt_r[2:0];
      item.bad  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_r     <= ROW_W'(1);
      bpp_r    <= BPP_REG_W'(1);
      in_row_r <= 1'b0;
      idx_r    <= '0;
      filt_r   <= '0;
      first_r  <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROW_BYTES: rb_r  <= cfg_wdata;
          CFG_BPP:       bpp_r <= cfg_wdata[BPP_REG_W-1:0];
          default:       rb_r  <= rb_r;
        endcase
      end
      if (fire) begin
        if (expect_filter) begin
          filt_r   <= data_byte;
          in_row_r <= 1'b1;
          idx_r    <= '0;
          if (image_start) begin
            first_r <= 1'b1;
          end
        end else if (last) begin
          in_row_r <= 1'b0;
          first_r  <= 1'b0;
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
    end
  end

endmodule

### rtl/core/psu_queue.sv
// Short request queue between the classifying front end and the reconstruction back end.
module psu_queue import psu_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  item_t  push_item,
  input  logic   pop,
  output item_t  head,
  output qstat_t stat
);

  item_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign head       = slot_r[rd_ptr_r];
  assign stat.full  = count_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign stat.empty = count_r == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

### rtl/core/psu_back.sv
// Back end: line buffer, pixel windows, filter reconstruction and the output register.
module psu_back import psu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  item_t      head,
  input  logic       q_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] pixel_byte,
  output logic       row_last,
  output logic       bad_filter
);

  logic [7:0] line_mem [ROW_BYTES_MAX];
  logic [7:0] mem_q_r;

  logic       r_valid_r;
  item_t      r_item_r;
  logic       fwd_r;
  logic [7:0] left_win_r [PIX_MAX];
  logic [7:0] up_win_r   [PIX_MAX];

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_bad_r;

  logic       exec_go;
  logic       r_load;
  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] c;
  logic [8:0] ab_sum;
  logic [7:0] pred;
  logic [7:0] res;

  assign exec_go = r_valid_r && (!out_valid_r || out_ready);
  assign r_load  = !q_empty && (!r_valid_r || exec_go);
  assign pop     = r_load;

  // Line buffer: read when a request enters the execute register, written when it retires.
  always_ff @(posedge clk) begin
    if (r_load) begin
      mem_q_r <= line_mem[head.idx];
    end
    if (exec_go) begin
      line_mem[r_item_r.idx] <= res;
    end
  end

  always_comb begin
    // With one-byte rows, a byte above that retires in the same cycle as this buffer read is not in mem_q_r yet.
    b      = r_item_r.first_row ? 8'd0 : (fwd_r ? left_win_r[0] : mem_q_r);
    a      = r_item_r.left_ok ? left_win_r[r_item_r.bpp_sel] : 8'd0;
    c      = (!r_item_r.first_row && r_item_r.left_ok) ? up_win_r[r_item_r.bpp_sel] : 8'd0;
    ab_sum = {1'b0, a} + {1'b0, b};
    unique case (r_item_r.filt)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = 8'd0;
    endcase
    res = r_item_r.data + pred;
  end

  always_ff @(posedge clk) begin
    if (r_load) begin
      r_item_r <= head;
      fwd_r    <= exec_go && (head.idx == r_item_r.idx);
    end
    if (exec_go) begin
      out_byte_r <= res;
      out_last_r <= r_item_r.last;
      out_bad_r  <= r_item_r.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < PIX_MAX; k++) begin
        left_win_r[k] <= 8'd0;
        up_win_r[k]   <= 8'd0;
      end
    end else begin
      if (r_load) begin
        r_valid_r <= 1'b1;
      end else if (exec_go) begin
        r_valid_r <= 1'b0;
      end
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (exec_go) begin
        for (int k = PIX_MAX - 1; k > 0; k--) begin
          left_win_r[k] <= left_win_r[k-1];
          up_win_r[k]   <= up_win_r[k-1];
        end
        left_win_r[0] <= res;
        up_win_r[0]   <= b;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign pixel_byte = out_byte_r;
  assign row_last   = out_last_r;
  assign bad_filter = out_bad_r;

endmodule
